>>> src/fccm_pkg.sv
// Shared types, constants and the control store of the cluster chain manager.
// Depends on nothing; used by fccm_ram and fat_cluster_chain_manager.
package fccm_pkg;

  localparam int TABLE_ENTRIES_DEF = 4096;
  localparam int ENTRY_W   = 32;
  localparam int CMD_W     = 3;
  localparam int CLUSTER_W = 12;
  localparam int STATUS_W  = 2;
  localparam int COUNT_W   = 13;
  localparam int MARK_W    = 28;
  localparam int PADDR_W   = 3;
  localparam int PDATA_W   = 32;
  localparam int UPC_W     = 5;

  // commands
  localparam logic [CMD_W-1:0] CMD_FIND_FREE     = 3'd0;
  localparam logic [CMD_W-1:0] CMD_LAST_OF_CHAIN = 3'd1;
  localparam logic [CMD_W-1:0] CMD_APPEND        = 3'd2;
  localparam logic [CMD_W-1:0] CMD_MARK_FREE     = 3'd3;
  localparam logic [CMD_W-1:0] CMD_MARK_USED     = 3'd4;
  localparam logic [CMD_W-1:0] CMD_ALLOC_LINKED  = 3'd5;
  localparam logic [CMD_W-1:0] CMD_FREE_CHAIN    = 3'd6;

  // status codes
  localparam logic [STATUS_W-1:0] ST_OK       = 2'd0;
  localparam logic [STATUS_W-1:0] ST_RESERVED = 2'd1;
  localparam logic [STATUS_W-1:0] ST_NO_FREE  = 2'd2;
  localparam logic [STATUS_W-1:0] ST_CORRUPT  = 2'd3;

  // register indexes (bit 2 of the byte address)
  localparam logic REG_ENTRIES    = 1'b0;
  localparam logic REG_END_MARKER = 1'b1;

  localparam logic [ENTRY_W-1:0] MEDIA_ENTRY      = 32'h0FFF_FFF8;
  localparam logic [ENTRY_W-1:0] RESERVED_ENTRY   = 32'hFFFF_FFFF;
  localparam logic [ENTRY_W-1:0] END_MARKER_RESET = 32'h0FFF_FFF8;
  localparam logic [COUNT_W-1:0] ENTRIES_RESET    = 13'd4096;
  localparam logic [MARK_W-1:0]  LOW28_MASK       = 28'hFFF_FFFF;

  typedef struct packed {
    logic [CMD_W-1:0]     command;
    logic [CLUSTER_W-1:0] cluster;
    logic [CLUSTER_W-1:0] second_cluster;
  } in_t;

  typedef struct packed {
    logic [CLUSTER_W-1:0] result_cluster;
    logic [STATUS_W-1:0]  status;
  } out_t;

  typedef logic [UPC_W-1:0] upc_t;

  // control store addresses
  localparam upc_t U_CLEAR       = 5'd0;
  localparam upc_t U_IDLE        = 5'd1;
  localparam upc_t U_DISPATCH    = 5'd2;
  localparam upc_t U_FF_INIT     = 5'd3;
  localparam upc_t U_FF_SCAN     = 5'd4;
  localparam upc_t U_NO_FREE     = 5'd5;
  localparam upc_t U_FOUND       = 5'd6;
  localparam upc_t U_ALLOC_END   = 5'd7;
  localparam upc_t U_ALLOC_LINK  = 5'd8;
  localparam upc_t U_WALK_INIT   = 5'd9;
  localparam upc_t U_WALK        = 5'd10;
  localparam upc_t U_BAD_LINK    = 5'd11;
  localparam upc_t U_WALK_FREE   = 5'd12;
  localparam upc_t U_BAD_FREE    = 5'd13;
  localparam upc_t U_WALK_END    = 5'd14;
  localparam upc_t U_LAST        = 5'd15;
  localparam upc_t U_APPEND_LINK = 5'd16;
  localparam upc_t U_APPEND_END  = 5'd17;
  localparam upc_t U_MARK        = 5'd18;
  localparam upc_t U_DONE        = 5'd19;

  typedef enum logic [4:0] {
    OP_NOP,
    OP_CLEAR,
    OP_LATCH,
    OP_PRECHECK,
    OP_SCAN_INIT,
    OP_SCAN,
    OP_SET_NO_FREE,
    OP_SET_RES_FREE,
    OP_WR_FREE_END,
    OP_WR_PREV_FREE,
    OP_WALK_INIT,
    OP_WALK,
    OP_WALK_FREE,
    OP_SET_CORRUPT,
    OP_SET_RES_LAST,
    OP_WR_LAST_SECOND,
    OP_WR_SECOND_END,
    OP_WR_MARK,
    OP_OUTPUT
  } op_e;

  typedef enum logic [3:0] {
    C_NEVER,
    C_ALWAYS,
    C_IN_WAIT,
    C_CLR_MORE,
    C_PRE_FAIL,
    C_N_LE1,
    C_RD_ZERO,
    C_SCAN_MORE,
    C_CMD_ALLOC,
    C_CLUSTER_ZERO,
    C_CMD_FREE_CHAIN,
    C_ENDS,
    C_LINK_OK,
    C_CMD_APPEND,
    C_OUT_BUSY
  } cond_e;

  // first matching jump wins; the dispatch flag sits between the two;
  // with no jump taken the step counter advances by one
  typedef struct packed {
    op_e   op;
    cond_e cond_a;
    upc_t  tgt_a;
    cond_e cond_b;
    upc_t  tgt_b;
    logic  dispatch;
  } uword_t;

  function automatic uword_t uw(input op_e op, input cond_e ca, input upc_t ta,
                                input cond_e cb, input upc_t tb, input logic disp);
    uword_t w;
    w.op       = op;
    w.cond_a   = ca;
    w.tgt_a    = ta;
    w.cond_b   = cb;
    w.tgt_b    = tb;
    w.dispatch = disp;
    return w;
  endfunction

  function automatic uword_t ucode(input upc_t a);
    uword_t w;
    case (a)
      U_CLEAR:       w = uw(OP_CLEAR, C_CLR_MORE, U_CLEAR, C_NEVER, U_IDLE, 1'b0);
      U_IDLE:        w = uw(OP_LATCH, C_IN_WAIT, U_IDLE, C_NEVER, U_IDLE, 1'b0);
      U_DISPATCH:    w = uw(OP_PRECHECK, C_PRE_FAIL, U_DONE, C_NEVER, U_DONE, 1'b1);
      U_FF_INIT:     w = uw(OP_SCAN_INIT, C_N_LE1, U_NO_FREE, C_NEVER, U_IDLE, 1'b0);
      U_FF_SCAN:     w = uw(OP_SCAN, C_RD_ZERO, U_FOUND, C_SCAN_MORE, U_FF_SCAN, 1'b0);
      U_NO_FREE:     w = uw(OP_SET_NO_FREE, C_ALWAYS, U_DONE, C_NEVER, U_IDLE, 1'b0);
      U_FOUND:       w = uw(OP_SET_RES_FREE, C_CMD_ALLOC, U_ALLOC_END, C_ALWAYS, U_DONE, 1'b0);
      U_ALLOC_END:   w = uw(OP_WR_FREE_END, C_CLUSTER_ZERO, U_DONE, C_NEVER, U_IDLE, 1'b0);
      U_ALLOC_LINK:  w = uw(OP_WR_PREV_FREE, C_ALWAYS, U_DONE, C_NEVER, U_IDLE, 1'b0);
      U_WALK_INIT:   w = uw(OP_WALK_INIT, C_CMD_FREE_CHAIN, U_WALK_FREE, C_NEVER, U_IDLE,
                            1'b0);
      U_WALK:        w = uw(OP_WALK, C_ENDS, U_WALK_END, C_LINK_OK, U_WALK, 1'b0);
      U_BAD_LINK:    w = uw(OP_SET_CORRUPT, C_ALWAYS, U_DONE, C_NEVER, U_IDLE, 1'b0);
      U_WALK_FREE:   w = uw(OP_WALK_FREE, C_ENDS, U_DONE, C_LINK_OK, U_WALK_FREE, 1'b0);
      U_BAD_FREE:    w = uw(OP_SET_CORRUPT, C_ALWAYS, U_DONE, C_NEVER, U_IDLE, 1'b0);
      U_WALK_END:    w = uw(OP_NOP, C_CMD_APPEND, U_APPEND_LINK, C_NEVER, U_IDLE, 1'b0);
      U_LAST:        w = uw(OP_SET_RES_LAST, C_ALWAYS, U_DONE, C_NEVER, U_IDLE, 1'b0);
      U_APPEND_LINK: w = uw(OP_WR_LAST_SECOND, C_NEVER, U_IDLE, C_NEVER, U_IDLE, 1'b0);
      U_APPEND_END:  w = uw(OP_WR_SECOND_END, C_ALWAYS, U_DONE, C_NEVER, U_IDLE, 1'b0);
      U_MARK:        w = uw(OP_WR_MARK, C_ALWAYS, U_DONE, C_NEVER, U_IDLE, 1'b0);
      U_DONE:        w = uw(OP_OUTPUT, C_OUT_BUSY, U_DONE, C_ALWAYS, U_IDLE, 1'b0);
      default:       w = uw(OP_NOP, C_ALWAYS, U_IDLE, C_NEVER, U_IDLE, 1'b0);
    endcase
    return w;
  endfunction

  // entry point of each command's routine
  function automatic upc_t dispatch_addr(input logic [CMD_W-1:0] cmd);
    upc_t a;
    case (cmd)
      CMD_FIND_FREE:     a = U_FF_INIT;
      CMD_LAST_OF_CHAIN: a = U_WALK_INIT;
      CMD_APPEND:        a = U_WALK_INIT;
      CMD_MARK_FREE:     a = U_MARK;
      CMD_MARK_USED:     a = U_MARK;
      CMD_ALLOC_LINKED:  a = U_FF_INIT;
      CMD_FREE_CHAIN:    a = U_WALK_INIT;
      default:           a = U_DONE;
    endcase
    return a;
  endfunction

endpackage

>>> src/fccm_ram.sv
// Generic single-port-write, single-port-read RAM with registered read data.
// Write-first on a same-address collision. Depends on fccm_pkg for defaults.
module fccm_ram #(
  parameter int WIDTH = fccm_pkg::ENTRY_W,
  parameter int DEPTH = fccm_pkg::TABLE_ENTRIES_DEF
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    // forward the write so a freed entry reads back as free at once
    if (we && (waddr == raddr)) begin
      rdata <= wdata;
    end else begin
      rdata <= mem[raddr];
    end
  end

endmodule

>>> src/fat_cluster_chain_manager.sv
// Cluster chain manager: one command in, one result out, run by a microcoded sequencer
// over an allocation table in fccm_ram (uses fccm_pkg). Find free and allocate scan the
// table with one read per cycle; last of chain, append and free chain walk a chain's links.
// One command at a time; the next transfer is taken the cycle after the result is queued.
// Reset (rst, synchronous) formats the table with the input stalled.
module fat_cluster_chain_manager #(
  parameter int TABLE_ENTRIES = fccm_pkg::TABLE_ENTRIES_DEF
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          in_valid,
  output logic                          in_stall,
  input  fccm_pkg::in_t                 in_data,
  output logic                          out_valid,
  input  logic                          out_stall,
  output fccm_pkg::out_t                out_data,
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [fccm_pkg::PADDR_W-1:0]  paddr,
  input  logic [fccm_pkg::PDATA_W-1:0]  pwdata,
  output logic [fccm_pkg::PDATA_W-1:0]  prdata,
  output logic                          pready
);

  localparam int AW = $clog2(TABLE_ENTRIES);
  localparam int NW = fccm_pkg::COUNT_W;
  localparam int EW = fccm_pkg::ENTRY_W;
  localparam int CW = fccm_pkg::CLUSTER_W;
  localparam int MW = fccm_pkg::MARK_W;

  // configuration registers
  logic [NW-1:0] entries_in_use;
  logic [MW-1:0] end_marker;

  // sequencer
  fccm_pkg::upc_t   upc;
  fccm_pkg::upc_t   upc_next;
  fccm_pkg::uword_t ctl;
  logic [AW-1:0]    clr_cnt;

  // datapath registers
  logic [fccm_pkg::CMD_W-1:0]    cmd;
  logic [CW-1:0]                 c;
  logic [CW-1:0]                 c2;
  logic [NW-1:0]                 i;
  logic [NW-1:0]                 f;
  logic [NW-1:0]                 cur;
  logic [NW-1:0]                 prev;
  logic [NW-1:0]                 links;
  logic [CW-1:0]                 res;
  logic [fccm_pkg::STATUS_W-1:0] st;

  // table port
  logic          ram_we;
  logic [AW-1:0] ram_waddr;
  logic [EW-1:0] ram_wdata;
  logic [AW-1:0] ram_raddr;
  logic [EW-1:0] ram_rdata;

  logic [NW-1:0]                     n;
  logic [fccm_pkg::STATUS_W-1:0]     pre_st;
  logic                              ends;
  logic                              link_ok;
  logic                              out_busy;
  logic [EW-1:0]                     end_word;
  logic [EW-1:0]                     init_word;
  logic [(1 << $bits(fccm_pkg::cond_e))-1:0] cflag;

  // ---------------- configuration port ----------------
  assign pready = 1'b1;
  assign prdata = (paddr[2] == fccm_pkg::REG_ENTRIES) ? EW'(entries_in_use) : EW'(end_marker);

  always_ff @(posedge clk) begin
    if (rst) begin
      entries_in_use <= fccm_pkg::ENTRIES_RESET;
      end_marker     <= fccm_pkg::END_MARKER_RESET[MW-1:0];
    end else if (psel && penable && pwrite && pready) begin
      if (paddr[2] == fccm_pkg::REG_ENTRIES) begin
        entries_in_use <= pwdata[NW-1:0];
      end else begin
        end_marker <= pwdata[MW-1:0] & fccm_pkg::LOW28_MASK;
      end
    end
  end

  assign n = (32'(entries_in_use) < 32'(TABLE_ENTRIES)) ? entries_in_use : NW'(TABLE_ENTRIES);
  assign end_word = EW'(end_marker);

  // ---------------- conditions ----------------
  always_comb begin
    pre_st = fccm_pkg::ST_OK;
    case (cmd)
      fccm_pkg::CMD_LAST_OF_CHAIN, fccm_pkg::CMD_MARK_FREE,
      fccm_pkg::CMD_MARK_USED, fccm_pkg::CMD_FREE_CHAIN: begin
        if (c < CW'(2)) begin
          pre_st = fccm_pkg::ST_RESERVED;
        end else if (NW'(c) >= n) begin
          pre_st = fccm_pkg::ST_CORRUPT;
        end
      end
      fccm_pkg::CMD_APPEND: begin
        if ((c < CW'(2)) || (c2 < CW'(2))) begin
          pre_st = fccm_pkg::ST_RESERVED;
        end else if ((NW'(c) >= n) || (NW'(c2) >= n)) begin
          pre_st = fccm_pkg::ST_CORRUPT;
        end
      end
      fccm_pkg::CMD_ALLOC_LINKED: begin
        if (c == CW'(1)) begin
          pre_st = fccm_pkg::ST_RESERVED;
        end else if ((c != '0) && (NW'(c) >= n)) begin
          pre_st = fccm_pkg::ST_CORRUPT;
        end
      end
      default: begin
        pre_st = fccm_pkg::ST_OK;
      end
    endcase
  end

  // a free entry also ends a chain
  assign ends    = (ram_rdata == '0) || (ram_rdata[MW-1:0] >= end_marker);
  assign link_ok = (ram_rdata >= EW'(2)) && (ram_rdata < EW'(n)) && (links < n);
  assign out_busy = out_valid && out_stall;

  always_comb begin
    cflag = '0;
    cflag[fccm_pkg::C_ALWAYS]         = 1'b1;
    cflag[fccm_pkg::C_IN_WAIT]        = !in_valid;
    cflag[fccm_pkg::C_CLR_MORE]       = (clr_cnt != AW'(TABLE_ENTRIES - 1));
    cflag[fccm_pkg::C_PRE_FAIL]       = (pre_st != fccm_pkg::ST_OK);
    cflag[fccm_pkg::C_N_LE1]          = (n <= NW'(1));
    cflag[fccm_pkg::C_RD_ZERO]        = (ram_rdata == '0);
    cflag[fccm_pkg::C_SCAN_MORE]      = (i < n);
    cflag[fccm_pkg::C_CMD_ALLOC]      = (cmd == fccm_pkg::CMD_ALLOC_LINKED);
    cflag[fccm_pkg::C_CLUSTER_ZERO]   = (c == '0);
    cflag[fccm_pkg::C_CMD_FREE_CHAIN] = (cmd == fccm_pkg::CMD_FREE_CHAIN);
    cflag[fccm_pkg::C_ENDS]           = ends;
    cflag[fccm_pkg::C_LINK_OK]        = link_ok;
    cflag[fccm_pkg::C_CMD_APPEND]     = (cmd == fccm_pkg::CMD_APPEND);
    cflag[fccm_pkg::C_OUT_BUSY]       = out_busy;
  end

  // ---------------- sequencer ----------------
  assign ctl      = fccm_pkg::ucode(upc);
  assign in_stall = (upc != fccm_pkg::U_IDLE);

  always_comb begin
    if (cflag[ctl.cond_a]) begin
      upc_next = ctl.tgt_a;
    end else if (ctl.dispatch) begin
      upc_next = fccm_pkg::dispatch_addr(cmd);
    end else if (cflag[ctl.cond_b]) begin
      upc_next = ctl.tgt_b;
    end else begin
      upc_next = fccm_pkg::upc_t'(upc + 1'b1);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      upc       <= fccm_pkg::U_CLEAR;
      clr_cnt   <= '0;
      out_valid <= 1'b0;
    end else begin
      upc <= upc_next;
      if (ctl.op == fccm_pkg::OP_CLEAR) begin
        clr_cnt <= clr_cnt + 1'b1;
      end
      if ((ctl.op == fccm_pkg::OP_OUTPUT) && !out_busy) begin
        out_valid <= 1'b1;
      end else if (out_valid && !out_stall) begin
        out_valid <= 1'b0;
      end
    end
  end

  // ---------------- datapath ----------------
  always_ff @(posedge clk) begin
    case (ctl.op)
      fccm_pkg::OP_LATCH: begin
        cmd <= in_data.command;
        c   <= in_data.cluster;
        c2  <= in_data.second_cluster;
      end
      fccm_pkg::OP_PRECHECK: begin
        st  <= pre_st;
        res <= '0;
      end
      fccm_pkg::OP_SCAN_INIT: begin
        i <= NW'(2);
      end
      fccm_pkg::OP_SCAN: begin
        // read data belongs to index i - 1
        i <= i + 1'b1;
        f <= i - 1'b1;
      end
      fccm_pkg::OP_SET_NO_FREE: begin
        st <= fccm_pkg::ST_NO_FREE;
      end
      fccm_pkg::OP_SET_RES_FREE: begin
        res <= f[CW-1:0];
      end
      fccm_pkg::OP_WALK_INIT: begin
        cur   <= NW'(c);
        links <= '0;
      end
      fccm_pkg::OP_WALK, fccm_pkg::OP_WALK_FREE: begin
        prev  <= cur;
        cur   <= ram_rdata[NW-1:0];
        links <= links + 1'b1;
      end
      fccm_pkg::OP_SET_CORRUPT: begin
        st <= fccm_pkg::ST_CORRUPT;
      end
      fccm_pkg::OP_SET_RES_LAST: begin
        res <= prev[CW-1:0];
      end
      fccm_pkg::OP_OUTPUT: begin
        if (!out_busy) begin
          out_data.result_cluster <= res;
          out_data.status         <= st;
        end
      end
      default: begin
      end
    endcase
  end

  // ---------------- table access ----------------
  always_comb begin
    if (clr_cnt == '0) begin
      init_word = fccm_pkg::MEDIA_ENTRY;
    end else if (clr_cnt == AW'(1)) begin
      init_word = fccm_pkg::RESERVED_ENTRY;
    end else if (clr_cnt == AW'(2)) begin
      init_word = fccm_pkg::END_MARKER_RESET;
    end else begin
      init_word = '0;
    end
  end

  always_comb begin
    ram_we    = 1'b0;
    ram_waddr = clr_cnt;
    ram_wdata = '0;
    ram_raddr = AW'(i);
    case (ctl.op)
      fccm_pkg::OP_CLEAR: begin
        ram_we    = 1'b1;
        ram_wdata = init_word;
      end
      fccm_pkg::OP_SCAN_INIT: begin
        ram_raddr = AW'(1);
      end
      fccm_pkg::OP_SCAN: begin
        ram_raddr = AW'(i);
      end
      fccm_pkg::OP_WR_FREE_END: begin
        ram_we    = 1'b1;
        ram_waddr = AW'(f);
        ram_wdata = end_word;
      end
      fccm_pkg::OP_WR_PREV_FREE: begin
        ram_we    = 1'b1;
        ram_waddr = AW'(c);
        ram_wdata = EW'(f);
      end
      fccm_pkg::OP_WALK_INIT: begin
        ram_raddr = AW'(c);
      end
      fccm_pkg::OP_WALK: begin
        ram_raddr = AW'(ram_rdata);
      end
      fccm_pkg::OP_WALK_FREE: begin
        // drop the entry just read, follow its link
        ram_we    = 1'b1;
        ram_waddr = AW'(cur);
        ram_wdata = '0;
        ram_raddr = AW'(ram_rdata);
      end
      fccm_pkg::OP_WR_LAST_SECOND: begin
        ram_we    = 1'b1;
        ram_waddr = AW'(prev);
        ram_wdata = EW'(c2);
      end
      fccm_pkg::OP_WR_SECOND_END: begin
        ram_we    = 1'b1;
        ram_waddr = AW'(c2);
        ram_wdata = end_word;
      end
      fccm_pkg::OP_WR_MARK: begin
        ram_we    = 1'b1;
        ram_waddr = AW'(c);
        ram_wdata = (cmd == fccm_pkg::CMD_MARK_FREE) ? '0 : end_word;
      end
      default: begin
        ram_we = 1'b0;
      end
    endcase
  end

  fccm_ram #(
    .WIDTH(EW),
    .DEPTH(TABLE_ENTRIES)
  ) u_table (
    .clk  (clk),
    .we   (ram_we),
    .waddr(ram_waddr),
    .wdata(ram_wdata),
    .raddr(ram_raddr),
    .rdata(ram_rdata)
  );

endmodule
